// ===== rtl/core/htc_pkg.sv =====
// ----------------------------------------------------------------------------
// htc_pkg
// shared constants, types and helpers for the hyperbolic tone curve core
// ----------------------------------------------------------------------------
package htc_pkg;

   localparam int unsigned CHANNEL_BITS_DEFAULT = 16;
   localparam int unsigned FIELD_BITS           = 16;
   localparam int unsigned STRENGTH_BITS        = 16;
   localparam int unsigned NUM_LANES            = 4;
   localparam int unsigned CSR_INDEX_BITS       = 1;

   // |s| fits in 16 bits (32768 at most), 4096+|s| (36864 at most) is held in 17
   localparam int unsigned MAG_BITS   = 16;
   localparam int unsigned SCALE_BITS = 17;
   localparam int unsigned NUM_BITS   = FIELD_BITS + SCALE_BITS + FIELD_BITS;  // 49
   localparam int unsigned DEN_BITS   = FIELD_BITS + SCALE_BITS;               // 33
   localparam int unsigned QUO_BITS   = FIELD_BITS + 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COLOR_STRENGTH = 1'b0,
      CSR_ALPHA_STRENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] red;
      logic [FIELD_BITS-1:0] green;
      logic [FIELD_BITS-1:0] blue;
      logic [FIELD_BITS-1:0] alpha;
   } pixel_type;

   // per-channel control that travels down a lane next to the quotient
   typedef struct packed {
      logic                  bypass;
      logic                  mirror;
      logic [FIELD_BITS-1:0] orig;
   } lane_ctrl_type;

endpackage

// ===== rtl/core/htc_stream_if.sv =====
// ----------------------------------------------------------------------------
// htc_stream_if
// valid/ready channel carrying one rgba pixel
// ----------------------------------------------------------------------------
interface htc_stream_if;
   import htc_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/htc_lane.sv =====
// ----------------------------------------------------------------------------
// htc_lane
// one channel lane: operand setup, pipelined restoring divider, rounding
// ----------------------------------------------------------------------------
module htc_lane #(
   parameter int unsigned CHANNEL_BITS = htc_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [htc_pkg::FIELD_BITS-1:0]      chan,
   input  logic [htc_pkg::STRENGTH_BITS-1:0]   strength,
   output logic [htc_pkg::FIELD_BITS-1:0]      result
);
   import htc_pkg::*;

   localparam logic [FIELD_BITS-1:0] MAXV = FIELD_BITS'((32'd1 << CHANNEL_BITS) - 32'd1);
   localparam int unsigned DIV_STAGES = QUO_BITS;

   // stage 0: operands
   logic [MAG_BITS-1:0]   mag;
   logic                  mirror;
   logic                  bypass;
   logic [FIELD_BITS-1:0] u;

   assign mirror = ~strength[STRENGTH_BITS-1];
   assign mag    = strength[STRENGTH_BITS-1] ? MAG_BITS'(-strength) : strength;
   assign bypass = (strength == '0) || (chan == '0) || (chan >= MAXV);
   assign u      = mirror ? FIELD_BITS'(MAXV - chan) : chan;

   // stage 1 registers: products
   logic [SCALE_BITS+FIELD_BITS-1:0] mu_ff, mu_in;      // max*(4096+|s|)
   logic [DEN_BITS-1:0]              den_ff, den_in;
   logic [FIELD_BITS-1:0]            u_ff;
   lane_ctrl_type                    c1_ff, c1_in;

   assign mu_in  = (SCALE_BITS+FIELD_BITS)'(MAXV) *
                   (SCALE_BITS+FIELD_BITS)'({1'b0, mag} + SCALE_BITS'(4096));
   assign den_in = (DEN_BITS'(MAXV) << 12) + DEN_BITS'(mag) * DEN_BITS'(u);
   assign c1_in  = '{bypass: bypass, mirror: mirror, orig: chan};

   always_ff @(posedge clock) begin
      if (advance) begin
         mu_ff  <= mu_in;
         den_ff <= den_in;
         u_ff   <= u;
         c1_ff  <= c1_in;
      end
   end

   // stage 2: numerator, split product (33x16) registered
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] den2_ff;
   lane_ctrl_type       c2_ff;

   assign num_in = NUM_BITS'(mu_ff) * NUM_BITS'(u_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff  <= num_in;
         den2_ff <= den_ff;
         c2_ff   <= c1_ff;
      end
   end

   // divider pipeline: one quotient bit per stage, msb first
   // quotient < 2*MAX so QUO_BITS bits suffice; remainder < den
   logic [DEN_BITS:0]     rem_ff  [1:DIV_STAGES];
   logic [QUO_BITS-1:0]   quo_ff  [1:DIV_STAGES];
   logic [NUM_BITS-1:0]   nsh_ff  [1:DIV_STAGES];
   logic [DEN_BITS-1:0]   dv_ff   [1:DIV_STAGES];
   lane_ctrl_type         cd_ff   [1:DIV_STAGES];

   // num >> QUO_BITS is below den, since the quotient fits in QUO_BITS bits, so the
   // remainder starts as num >> QUO_BITS
   logic [DEN_BITS:0] rem_init;
   assign rem_init = (DEN_BITS+1)'(num_ff >> QUO_BITS);

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      logic [DEN_BITS:0]   r_cur;
      logic [QUO_BITS-1:0] q_cur;
      logic [NUM_BITS-1:0] n_cur;
      logic [DEN_BITS-1:0] d_cur;
      lane_ctrl_type       c_cur;
      logic [DEN_BITS+1:0] trial;
      logic [DEN_BITS:0]   rem_in;
      logic                bit_q;

      if (g == 0) begin : g_head
         assign r_cur = rem_init;
         assign q_cur = '0;
         assign n_cur = num_ff << (NUM_BITS - QUO_BITS);
         assign d_cur = den2_ff;
         assign c_cur = c2_ff;
      end else begin : g_body
         assign r_cur = rem_ff[g];
         assign q_cur = quo_ff[g];
         assign n_cur = nsh_ff[g];
         assign d_cur = dv_ff[g];
         assign c_cur = cd_ff[g];
      end

      assign trial  = {r_cur, n_cur[NUM_BITS-1]};
      assign bit_q  = trial >= (DEN_BITS+2)'(d_cur);
      assign rem_in = bit_q ? (DEN_BITS+1)'(trial - (DEN_BITS+2)'(d_cur))
                            : (DEN_BITS+1)'(trial);

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[g+1] <= rem_in;
            quo_ff[g+1] <= {q_cur[QUO_BITS-2:0], bit_q};
            nsh_ff[g+1] <= n_cur << 1;
            dv_ff[g+1]  <= d_cur;
            cd_ff[g+1]  <= c_cur;
         end
      end
   end

   // final: rounding and mirroring
   logic [QUO_BITS-1:0] q;
   logic [QUO_BITS-1:0] qc;
   lane_ctrl_type       cf;

   assign q  = quo_ff[DIV_STAGES];
   assign cf = cd_ff[DIV_STAGES];
   assign qc = (rem_ff[DIV_STAGES] != '0) ? QUO_BITS'(q + 1'b1) : q;

   always_comb begin
      if (cf.bypass) begin
         result = cf.orig;
      end else if (!cf.mirror) begin
         result = q[FIELD_BITS-1:0];
      end else if (qc > QUO_BITS'(MAXV)) begin
         result = '0;
      end else begin
         result = FIELD_BITS'(QUO_BITS'(MAXV) - qc);
      end
   end

endmodule

// ===== rtl/core/hyperbolic_tone_curve_core.sv =====
// pipeline: 20 register stages (2 product stages, 17 divider stages, then the
//   output register)
// throughput: one request per cycle unless back-pressure stalls the pipe; each lane's divider is fully pipelined
// reset: synchronous active-high reset clears strengths to zero and drops
//   all in-flight valid bits
// ----------------------------------------------------------------------------
// hyperbolic_tone_curve_core
// four parallel curve lanes (rgb + alpha) merged into one output pixel
// ----------------------------------------------------------------------------
module hyperbolic_tone_curve_core #(
   parameter int unsigned CHANNEL_BITS = htc_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   htc_stream_if.sink                             req,
   htc_stream_if.source                           rsp,
   input  logic                                   csr_write_enable,
   input  logic [htc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [htc_pkg::STRENGTH_BITS-1:0]      csr_write_data
);
   import htc_pkg::*;

   // lane pipeline depth: product, numerator and divider stages
   localparam int unsigned DEPTH = 2 + QUO_BITS;

   // strength registers
   logic [STRENGTH_BITS-1:0] color_strength_ff;
   logic [STRENGTH_BITS-1:0] alpha_strength_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_strength_ff <= '0;
         alpha_strength_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_COLOR_STRENGTH: color_strength_ff <= csr_write_data;
            CSR_ALPHA_STRENGTH: alpha_strength_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // whole pipe moves together; it stalls only when the output is full and
   // the last stage holds a request
   logic [DEPTH-1:0] vld_ff;
   logic             out_vld_ff;
   pixel_type        out_ff;
   logic             advance;
   logic             out_free;

   assign out_free  = !out_vld_ff || rsp.ready;
   assign advance   = out_free || !vld_ff[DEPTH-1];
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req.valid};
      end
   end

   // lanes
   logic [FIELD_BITS-1:0] lane_res [NUM_LANES];

   htc_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_red (
      .clock(clock), .advance(advance),
      .chan(req.data.red), .strength(color_strength_ff), .result(lane_res[0])
   );
   htc_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_green (
      .clock(clock), .advance(advance),
      .chan(req.data.green), .strength(color_strength_ff), .result(lane_res[1])
   );
   htc_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_blue (
      .clock(clock), .advance(advance),
      .chan(req.data.blue), .strength(color_strength_ff), .result(lane_res[2])
   );
   htc_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_alpha (
      .clock(clock), .advance(advance),
      .chan(req.data.alpha), .strength(alpha_strength_ff), .result(lane_res[3])
   );

   // merge lanes into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && vld_ff[DEPTH-1]) begin
         out_ff <= '{red: lane_res[0], green: lane_res[1],
                     blue: lane_res[2], alpha: lane_res[3]};
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.data  = out_ff;

`ifndef SYNTHESIS
   // a stalled result keeps its pixel
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");

   // the pipe only stalls when its tail and the output are both busy
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> vld_ff[DEPTH-1] && out_vld_ff && !rsp.ready)
      else $error("pipe stalled without back-pressure");

   // a request in the last stage moves to the output when it is free
   a_move: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH-1] && out_free |=> out_vld_ff)
      else $error("request lost at merge stage");
`endif

endmodule
